>>> design/hcbd_pkg.sv
package hcbd_pkg;

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharLf = 8'h0a;

  localparam logic [2:0] CauseClean  = 3'd0;
  localparam logic [2:0] CauseZero   = 3'd1;
  localparam logic [2:0] CauseBad    = 3'd2;
  localparam logic [2:0] CauseTrunc  = 3'd3;
  localparam logic [2:0] CauseUnterm = 3'd4;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_done;
    logic [2:0] stop_cause;
    logic       none_decoded;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.value = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.value = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> design/hcbd_in_if.sv
interface hcbd_in_if;
  logic               valid;
  logic               ready;
  hcbd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/hcbd_out_if.sv
interface hcbd_out_if;
  logic                valid;
  logic                ready;
  hcbd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/hcbd_core.sv
module hcbd_core #(
  parameter int SizeBits = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  hcbd_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output hcbd_pkg::out_item_t res_o
);
  import hcbd_pkg::*;

  localparam logic [1:0] PhSize = 2'd0;
  localparam logic [1:0] PhData = 2'd1;
  localparam logic [1:0] PhSkip = 2'd2;
  localparam logic [1:0] PhStop = 2'd3;

  logic [1:0]          phase_q, phase_d;
  logic [SizeBits-1:0] accum_q, accum_d;
  logic                has_digit_q, has_digit_d;
  logic                line_bad_q, line_bad_d;
  logic                pending_cr_q, pending_cr_d;
  logic [SizeBits-1:0] left_q, left_d;
  logic                chunk_seen_q, chunk_seen_d;
  logic [2:0]          reason_q, reason_d;

  logic       pass;
  logic [2:0] cause;
  hex_digit_t hex;
  logic [7:0] c;

  assign c   = item_i.body_byte;
  assign hex = hex_decode(c);

  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    has_digit_d  = has_digit_q;
    line_bad_d   = line_bad_q;
    pending_cr_d = pending_cr_q;
    left_d       = left_q;
    chunk_seen_d = chunk_seen_q;
    reason_d     = reason_q;
    pass         = 1'b0;
    case (phase_q)
      PhSize: begin
        if (pending_cr_q && c == CharLf) begin
          if (line_bad_q || !has_digit_q) begin
            phase_d  = PhStop;
            reason_d = CauseBad;
          end else if (accum_q == '0) begin
            phase_d  = PhStop;
            reason_d = CauseZero;
          end else begin
            phase_d = PhData;
            left_d  = accum_q;
          end
          accum_d      = '0;
          has_digit_d  = 1'b0;
          line_bad_d   = 1'b0;
          pending_cr_d = 1'b0;
        end else begin
          line_bad_d = line_bad_q | pending_cr_q;
          if (c == CharCr) begin
            pending_cr_d = 1'b1;
          end else begin
            pending_cr_d = 1'b0;
            if (!hex.ok) begin
              line_bad_d = 1'b1;
            end else begin
              has_digit_d = 1'b1;
              if (!line_bad_d) begin
                // one more digit fits only while the top nibble is clear
                if (accum_q[SizeBits-1 -: 4] != 4'd0) begin
                  line_bad_d = 1'b1;
                end else begin
                  accum_d = {accum_q[SizeBits-5:0], hex.value};
                end
              end
            end
          end
        end
      end
      PhData: begin
        pass = 1'b1;
        if (left_q != '0) left_d = left_q - SizeBits'(1);
        if (left_d == '0) begin
          chunk_seen_d = 1'b1;
          phase_d      = PhSkip;
          left_d       = SizeBits'(2);
        end
      end
      PhSkip: begin
        if (left_q != '0) left_d = left_q - SizeBits'(1);
        if (left_d == '0) begin
          phase_d      = PhSize;
          accum_d      = '0;
          has_digit_d  = 1'b0;
          line_bad_d   = 1'b0;
          pending_cr_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cause = CauseClean;
    if (item_i.final_byte) begin
      if (phase_d == PhStop) cause = reason_d;
      else if (phase_d == PhData) cause = CauseTrunc;
      else if (phase_d == PhSize && (has_digit_d || line_bad_d || pending_cr_d))
        cause = CauseUnterm;
    end
  end

  assign res_valid_o         = pass | item_i.final_byte;
  assign res_o.payload_byte  = pass ? c : 8'd0;
  assign res_o.payload_valid = pass;
  assign res_o.body_done     = item_i.final_byte;
  assign res_o.stop_cause    = cause;
  assign res_o.none_decoded  = item_i.final_byte & ~chunk_seen_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      accum_q      <= '0;
      has_digit_q  <= 1'b0;
      line_bad_q   <= 1'b0;
      pending_cr_q <= 1'b0;
      left_q       <= '0;
      chunk_seen_q <= 1'b0;
      reason_q     <= CauseClean;
    end else if (fire_i) begin
      if (item_i.final_byte) begin
        // the final byte closes the body, next byte starts a fresh one
        phase_q      <= PhSize;
        accum_q      <= '0;
        has_digit_q  <= 1'b0;
        line_bad_q   <= 1'b0;
        pending_cr_q <= 1'b0;
        left_q       <= '0;
        chunk_seen_q <= 1'b0;
        reason_q     <= CauseClean;
      end else begin
        phase_q      <= phase_d;
        accum_q      <= accum_d;
        has_digit_q  <= has_digit_d;
        line_bad_q   <= line_bad_d;
        pending_cr_q <= pending_cr_d;
        left_q       <= left_d;
        chunk_seen_q <= chunk_seen_d;
        reason_q     <= reason_d;
      end
    end
  end

  a_data_nonzero_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhData |-> left_q != '0)
    else $error("data phase entered with no bytes left");

  a_skip_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> (left_q == SizeBits'(1) || left_q == SizeBits'(2)))
    else $error("skip count out of range");

  a_stop_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhStop |-> (reason_q == CauseBad || reason_q == CauseZero))
    else $error("stopped without a stop reason");

endmodule

>>> design/http_chunked_body_decoder.sv
// Chunked body decoder: strips HTTP chunked framing from a stream of body bytes,
// one byte per transaction. Each accepted byte is held in an input register and
// decoded from that register against the framing state; chunk data bytes and the
// final byte of a body each produce one result, other framing bytes produce none.
// A new byte is accepted every cycle while no back-pressure holds the input;
// the output register lets a waiting result sit while the next byte is taken, and
// back-pressure reaches the input only when a result-producing byte meets a full,
// stalled output. The final result reports the stop cause and whether no chunk
// was completed, and the decoder then returns to its reset state for a new body.
module http_chunked_body_decoder #(
  parameter int SIZE_BITS = 31
) (
  input  logic clk_i,
  input  logic rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);
  import hcbd_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic      res_valid;
  out_item_t res;
  logic      s1_fire;
  logic      out_load;

  assign s1_fire   = s1_valid_q & (~res_valid | ~out_valid_q | out_o.ready);
  assign out_load  = s1_fire & res_valid;
  assign in_i.ready = ~s1_valid_q | s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) s1_item_q <= in_i.data;
  end

  hcbd_core #(
    .SizeBits(SIZE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .item_i     (s1_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_item_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with an empty input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten before its transaction");

  a_result_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.payload_valid || out_item_q.body_done))
    else $error("result carries neither data nor body end");

  a_mid_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_item_q.body_done) |->
      (out_item_q.stop_cause == CauseClean && !out_item_q.none_decoded))
    else $error("end status reported before body end");

endmodule

>>> bench/hcbd_frame_check.sv
`timescale 1ns / 1ps

module hcbd_frame_check (
  input  logic clk_i,
  input  logic rst_ni,
  hcbd_in_if   body_i,
  hcbd_out_if  result_i,
  output int   pending_o,
  output int   failures_o
);
  import hcbd_pkg::*;

  localparam int SizeBits = 31;
  localparam logic [35:0] SizeLimit = (36'd1 << SizeBits) - 36'd1;

  typedef enum logic [1:0] {
    LineSize,
    ChunkData,
    TrailPair,
    Halted
  } frame_phase_e;

  frame_phase_e         phase;
  logic [SizeBits-1:0]  size_acc;
  logic [SizeBits-1:0]  remaining;
  bit                   has_digit;
  bit                   line_bad;
  bit                   cr_seen;
  bit                   chunk_seen;
  logic [2:0]           halt_cause;

  out_item_t decoded_q[$];
  out_item_t predicted;
  out_item_t oldest;
  bit        emits;
  bit        field_bad;

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= "0" && c <= "9") begin
      v = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      v = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      v = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic clear_line();
    size_acc  = '0;
    has_digit = 1'b0;
    line_bad  = 1'b0;
    cr_seen   = 1'b0;
  endtask

  task automatic clear_frame();
    phase      = LineSize;
    clear_line();
    remaining  = '0;
    chunk_seen = 1'b0;
    halt_cause = CauseClean;
  endtask

  task automatic close_size_line();
    if (line_bad || !has_digit) begin
      phase      = Halted;
      halt_cause = CauseBad;
    end else if (size_acc == '0) begin
      phase      = Halted;
      halt_cause = CauseZero;
    end else begin
      phase     = ChunkData;
      remaining = size_acc;
    end
    clear_line();
  endtask

  task automatic decode_byte(input in_item_t it, output bit has_result, output out_item_t res);
    logic [7:0]  c;
    logic [3:0]  nib;
    logic [35:0] grown;
    bit          pass;
    c    = it.body_byte;
    pass = 1'b0;
    res  = '0;
    case (phase)
      LineSize: begin
        if (cr_seen && c == CharLf) begin
          close_size_line();
        end else begin
          // a cr not followed by lf counts as line content
          if (cr_seen) line_bad = 1'b1;
          if (c == CharCr) begin
            cr_seen = 1'b1;
          end else begin
            cr_seen = 1'b0;
            if (!hex_nibble(c, nib)) begin
              line_bad = 1'b1;
            end else begin
              has_digit = 1'b1;
              if (!line_bad) begin
                grown = (36'(size_acc) << 4) + 36'(nib);
                if (grown > SizeLimit) line_bad = 1'b1;
                else size_acc = grown[SizeBits-1:0];
              end
            end
          end
        end
      end
      ChunkData: begin
        pass = 1'b1;
        if (remaining != '0) remaining = remaining - SizeBits'(1);
        if (remaining == '0) begin
          chunk_seen = 1'b1;
          phase      = TrailPair;
          remaining  = SizeBits'(2);
        end
      end
      TrailPair: begin
        // the pair after chunk data is dropped unchecked
        if (remaining != '0) remaining = remaining - SizeBits'(1);
        if (remaining == '0) begin
          phase = LineSize;
          clear_line();
        end
      end
      default: ;
    endcase

    has_result = pass || it.final_byte;
    if (pass) begin
      res.payload_byte  = c;
      res.payload_valid = 1'b1;
    end
    if (it.final_byte) begin
      res.body_done    = 1'b1;
      res.none_decoded = !chunk_seen;
      if (phase == Halted) res.stop_cause = halt_cause;
      else if (phase == ChunkData) res.stop_cause = CauseTrunc;
      else if (phase == LineSize && (has_digit || line_bad || cr_seen))
        res.stop_cause = CauseUnterm;
      else res.stop_cause = CauseClean;
      clear_frame();
    end
  endtask

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      field_bad = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      decoded_q.delete();
      pending_o  <= 0;
      failures_o <= 0;
    end else begin
      if (body_i.valid === 1'b1 && body_i.ready === 1'b1) begin
        decode_byte(body_i.data, emits, predicted);
        if (emits) decoded_q.push_back(predicted);
      end
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, result_i.data);
          failures_o <= failures_o + 1;
        end else begin
          oldest    = decoded_q.pop_front();
          field_bad = 1'b0;
          check_field("payload_byte", oldest.payload_byte, result_i.data.payload_byte);
          check_field("payload_valid", 8'(oldest.payload_valid),
                      8'(result_i.data.payload_valid));
          check_field("body_done", 8'(oldest.body_done), 8'(result_i.data.body_done));
          check_field("stop_cause", 8'(oldest.stop_cause), 8'(result_i.data.stop_cause));
          check_field("none_decoded", 8'(oldest.none_decoded),
                      8'(result_i.data.none_decoded));
          if (field_bad) failures_o <= failures_o + 1;
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

>>> bench/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps

module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  logic clk_i;
  logic rst_ni;

  hcbd_in_if  body_bus ();
  hcbd_out_if decoded_bus ();

  int pending;
  int failures;

  logic [7:0] body_q[$];
  bit         calm;
  int         sent;

  http_chunked_body_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (body_bus),
    .out_o  (decoded_bus)
  );

  hcbd_frame_check frame_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .body_i     (body_bus),
    .result_i   (decoded_bus),
    .pending_o  (pending),
    .failures_o (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("http_chunked_body_decoder_tb failed");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void push_char(input logic [7:0] c);
    body_q.push_back(c);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void push_crlf();
    body_q.push_back(CharCr);
    body_q.push_back(CharLf);
  endfunction

  function automatic logic [7:0] odd_char();
    // non-hex characters, most just outside the digit and letter ranges
    string s;
    s = "/:@G`g; x";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      body_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    body_bus.valid <= 1'b1;
    body_bus.data  <= {b, fin};
    do @(posedge clk_i); while (body_bus.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) put_byte(body_q[i], i == body_q.size() - 1);
    sent += body_q.size();
    body_q.delete();
  endtask

  task automatic drain();
    body_bus.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic build_body();
    int    chunks;
    int    size;
    int    flaw;
    int    cut;
    string digits;
    chunks = $urandom_range(0, 4);
    repeat (chunks) begin
      size   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      flaw   = $urandom_range(0, 15);
      digits = $sformatf("%0h", size);
      if (flaw == 2) begin
        if ($urandom_range(0, 1)) digits = "80000000";
        else digits = "fffffffff";
      end
      // legal but huge: the body runs out inside the chunk
      if (flaw == 3) digits = "7fffffff";
      if (flaw == 4) digits = "";
      else repeat ($urandom_range(0, 2)) digits = {"0", digits};
      if ($urandom_range(0, 1)) digits = digits.toupper();
      push_text(digits);
      if (flaw == 0) push_char(odd_char());
      if (flaw == 1) begin
        push_char(CharCr);
        push_char("1");
      end
      push_crlf();
      repeat (size) push_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        push_char(8'($urandom_range(0, 255)));
        push_char(8'($urandom_range(0, 255)));
      end else begin
        push_crlf();
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 2) == 0) push_text("000");
      else push_text("0");
      push_crlf();
      if ($urandom_range(0, 1)) push_crlf();
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) push_char(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0 && body_q.size() > 0) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
    if (body_q.size() == 0) push_char(8'($urandom_range(0, 255)));
  endtask

  task automatic build_noise();
    string hexes;
    hexes = "09afAF";
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 3))
        0: push_char(8'($urandom_range(0, 255)));
        1: push_char(CharCr);
        2: push_char(CharLf);
        default: push_char(hexes[$urandom_range(0, hexes.len() - 1)]);
      endcase
    end
  endtask

  initial begin
    decoded_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      int stall;
      decoded_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      stall = idle_gap();
      if (stall > 0) begin
        decoded_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    body_bus.valid = 1'b0;
    body_bus.data  = '0;
    calm           = 1'b0;
    sent           = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // one chunk with extreme data bytes, body ends inside the trailing pair
    push_text("2");
    push_crlf();
    push_char(8'h00);
    push_char(8'hff);
    push_char(CharCr);
    send_body();
    // all-zero size with leading zero is the terminator
    push_text("00");
    push_crlf();
    send_body();
    // empty size line
    push_crlf();
    send_body();
    // lone cr, body ends before the line is closed
    push_text("1");
    push_char(CharCr);
    push_char("x");
    send_body();
    // partial chunk
    push_text("3");
    push_crlf();
    push_char("a");
    send_body();
    // size wider than the counter
    push_text("80000000");
    push_crlf();
    send_body();

    drain();
    sent = 0;
    while (sent < 550) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_body();
      send_body();
      if ($urandom_range(0, 5) == 0) drain();
    end

    body_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("http_chunked_body_decoder_tb passed");
    end else begin
      $display("http_chunked_body_decoder_tb failed");
    end
    $finish;
  end

endmodule
